[sv/quaternion_to_euler_angles_unit_macros.svh]
// ----------------------------------------------------------------------------
// Quaternion to Euler angles unit assertion macros
// Concurrent assertion wrappers, left empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_TO_EULER_ANGLES_UNIT_MACROS_SVH
`define QUATERNION_TO_EULER_ANGLES_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define QTEA_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define QTEA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define QTEA_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define QTEA_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

[sv/qtea_pkg.sv]
// ----------------------------------------------------------------------------
// Quaternion to Euler angles package
// Shared widths, sideband types and the arctangent table.
// ----------------------------------------------------------------------------
package qtea_pkg;

   localparam int VecW        = 36;
   localparam int SqW         = 62;
   localparam int RootW       = 31;
   localparam int SqrtStages  = 31;
   localparam int NumLanes    = 3;
   localparam int LaneHeading = 0;
   localparam int LanePitch   = 1;
   localparam int LaneBank    = 2;

   // arctangent of 2^-i, pi = 2^31
   localparam logic [31:0] ATAN_TAB [24] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   typedef struct packed {
      logic               locked;
      logic signed [15:0] lock_pitch;
   } lock_type;

   typedef struct packed {
      lock_type                lk;
      logic signed [VecW-1:0]  s;
      logic signed [VecW-1:0]  hy;
      logic signed [VecW-1:0]  hx;
      logic signed [VecW-1:0]  by;
      logic signed [VecW-1:0]  bx;
   } side_type;

   // table entry rounded half up to the accumulator scale
   function automatic logic [31:0] tab_entry(input int idx, input int shift);
      logic [32:0] t;
      t = {1'b0, ATAN_TAB[idx]};
      if (shift > 0) begin
         t = (t + (33'd1 << (shift - 1))) >> shift;
      end
      return t[31:0];
   endfunction

endpackage

[sv/qtea_delay.sv]
// ----------------------------------------------------------------------------
// Sideband delay line
// Fixed-depth shift register that keeps payload aligned with the pipeline.
// ----------------------------------------------------------------------------
module qtea_delay #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);

   logic [WIDTH-1:0] tap_ff [DEPTH];

   always_ff @(posedge clock) begin
      tap_ff[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
         tap_ff[i] <= tap_ff[i-1];
      end
   end

   assign dout = tap_ff[DEPTH-1];

endmodule

[sv/qtea_front.sv]
// ----------------------------------------------------------------------------
// Quaternion front end
// Component products, sin(pitch), lock test and the sqrt operand, 3 stages.
// ----------------------------------------------------------------------------
module qtea_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  logic                     kind,
   input  logic signed [15:0]       quat_w,
   input  logic signed [15:0]       quat_x,
   input  logic signed [15:0]       quat_y,
   input  logic signed [15:0]       quat_z,
   input  logic [14:0]              lock_threshold,
   output logic                     out_valid,
   output qtea_pkg::side_type       side,
   output logic [qtea_pkg::SqW-1:0] operand
);
   import qtea_pkg::*;

   localparam logic signed [VecW-1:0] Half = VecW'(64'sd1 << 29);
   localparam logic signed [VecW-1:0] One  = VecW'(64'sd1 << 30);
   localparam logic signed [VecW-1:0] Rnd  = VecW'(64'sd1 << 15);

   // stage a: products in q2.30
   logic signed [31:0] xx_ff, yy_ff, zz_ff, xy_ff, xz_ff, yz_ff, wx_ff, wy_ff, wz_ff;
   logic signed [31:0] xx_in, yy_in, zz_in, xy_in, xz_in, yz_in, wx_in, wy_in, wz_in;
   logic               kind_a_ff, valid_a_ff;

   assign xx_in = quat_x * quat_x;
   assign yy_in = quat_y * quat_y;
   assign zz_in = quat_z * quat_z;
   assign xy_in = quat_x * quat_y;
   assign xz_in = quat_x * quat_z;
   assign yz_in = quat_y * quat_z;
   assign wx_in = quat_w * quat_x;
   assign wy_in = quat_w * quat_y;
   assign wz_in = quat_w * quat_z;

   always_ff @(posedge clock) begin
      xx_ff <= xx_in; yy_ff <= yy_in; zz_ff <= zz_in;
      xy_ff <= xy_in; xz_ff <= xz_in; yz_ff <= yz_in;
      wx_ff <= wx_in; wy_ff <= wy_in; wz_ff <= wz_in;
      kind_a_ff <= kind;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else begin
         valid_a_ff <= in_valid;
      end
   end

   // stage b: combine terms, lock test
   logic signed [VecW-1:0] exx, eyy, ezz, exy, exz, eyz, gwx, gwy, gwz;
   logic signed [VecW-1:0] s_val, sat, p_full;
   logic [VecW-1:0]        mag;
   side_type               side_b_in, side_b_ff;
   logic [29:0]            mc_b_ff;
   logic                   big_b_ff, valid_b_ff;

   always_comb begin
      exx = VecW'(xx_ff);
      eyy = VecW'(yy_ff);
      ezz = VecW'(zz_ff);
      exy = VecW'(xy_ff);
      exz = VecW'(xz_ff);
      eyz = VecW'(yz_ff);
      gwx = kind_a_ff ? -VecW'(wx_ff) : VecW'(wx_ff);
      gwy = kind_a_ff ? -VecW'(wy_ff) : VecW'(wy_ff);
      gwz = kind_a_ff ? -VecW'(wz_ff) : VecW'(wz_ff);
      s_val = (gwx - eyz) <<< 1;
      mag = s_val[VecW-1] ? VecW'(-s_val) : VecW'(s_val);
      if (s_val > One) begin
         sat = One;
      end else if (s_val < -One) begin
         sat = -One;
      end else begin
         sat = s_val;
      end
      p_full = (sat + Rnd) >>> 16;
      side_b_in.lk.locked     = mag > VecW'({lock_threshold, 15'd0});
      side_b_in.lk.lock_pitch = p_full[15:0];
      side_b_in.s             = s_val;
      if (side_b_in.lk.locked) begin
         side_b_in.hy = gwy - exz;
         side_b_in.hx = Half - eyy - ezz;
      end else begin
         side_b_in.hy = exz + gwy;
         side_b_in.hx = Half - exx - eyy;
      end
      side_b_in.by = exy + gwz;
      side_b_in.bx = Half - exx - ezz;
   end

   always_ff @(posedge clock) begin
      side_b_ff <= side_b_in;
      mc_b_ff   <= mag[29:0];
      big_b_ff  <= |mag[VecW-1:30];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_b_ff <= 1'b0;
      end else begin
         valid_b_ff <= valid_a_ff;
      end
   end

   // stage c: 1 - s^2 in q.60
   logic [59:0]    sq;
   logic [SqW-1:0] operand_in, operand_ff;
   side_type       side_c_ff;
   logic           valid_c_ff;

   assign sq = mc_b_ff * mc_b_ff;
   assign operand_in = big_b_ff ? '0 : ((SqW'(1) << 60) - SqW'(sq));

   always_ff @(posedge clock) begin
      side_c_ff  <= side_b_ff;
      operand_ff <= operand_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_c_ff <= 1'b0;
      end else begin
         valid_c_ff <= valid_b_ff;
      end
   end

   assign out_valid = valid_c_ff;
   assign side      = side_c_ff;
   assign operand   = operand_ff;

endmodule

[sv/qtea_sqrt.sv]
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One result bit per stage, floor(sqrt) of the operand.
// ----------------------------------------------------------------------------
module qtea_sqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic [qtea_pkg::SqW-1:0]   operand,
   output logic                       out_valid,
   output logic [qtea_pkg::RootW-1:0] root
);
   import qtea_pkg::*;

   logic [SqW-1:0] v_ff [SqrtStages];
   logic [SqW-1:0] r_ff [SqrtStages];
   logic           valid_ff [SqrtStages];

   for (genvar j = 0; j < SqrtStages; j++) begin : g_stage
      localparam logic [SqW-1:0] Bit = SqW'(1) << (2 * (SqrtStages - 1 - j));
      logic [SqW-1:0] v_src, r_src, trial, v_in, r_in;
      logic           valid_src;

      if (j == 0) begin : g_first
         assign v_src     = operand;
         assign r_src     = '0;
         assign valid_src = in_valid;
      end else begin : g_next
         assign v_src     = v_ff[j-1];
         assign r_src     = r_ff[j-1];
         assign valid_src = valid_ff[j-1];
      end

      always_comb begin
         trial = r_src + Bit;
         if (v_src >= trial) begin
            v_in = v_src - trial;
            r_in = (r_src >> 1) + Bit;
         end else begin
            v_in = v_src;
            r_in = r_src >> 1;
         end
      end

      always_ff @(posedge clock) begin
         v_ff[j] <= v_in;
         r_ff[j] <= r_in;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else begin
            valid_ff[j] <= valid_src;
         end
      end
   end

   assign out_valid = valid_ff[SqrtStages-1];
   assign root      = r_ff[SqrtStages-1][RootW-1:0];

endmodule

[sv/qtea_cordic.sv]
// ----------------------------------------------------------------------------
// Vectoring CORDIC, three lanes
// Quarter-turn pre-rotation then one micro-rotation per stage per lane.
// ----------------------------------------------------------------------------
module qtea_cordic #(
   parameter int STEPS      = 16,
   parameter int ANGLE_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  logic signed [qtea_pkg::VecW-1:0]  vec_y [qtea_pkg::NumLanes],
   input  logic signed [qtea_pkg::VecW-1:0]  vec_x [qtea_pkg::NumLanes],
   output logic                              out_valid,
   output logic signed [ANGLE_BITS+1:0]      angle [qtea_pkg::NumLanes]
);
   import qtea_pkg::*;

   localparam int ZW = ANGLE_BITS + 2;
   localparam logic signed [ZW-1:0] Quarter = ZW'(1) << (ANGLE_BITS - 2);

   logic signed [VecW-1:0] x_ff [STEPS+1][NumLanes];
   logic signed [VecW-1:0] y_ff [STEPS+1][NumLanes];
   logic signed [ZW-1:0]   z_ff [STEPS+1][NumLanes];
   logic                   zero_ff [STEPS+1][NumLanes];
   logic                   valid_ff [STEPS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
      end
   end

   for (genvar l = 0; l < NumLanes; l++) begin : g_lane
      logic signed [VecW-1:0] x_in, y_in;
      logic signed [ZW-1:0]   z_in;

      // pre-rotation into the right half plane
      always_comb begin
         x_in = vec_x[l];
         y_in = vec_y[l];
         z_in = '0;
         if (vec_x[l] < 0) begin
            if (vec_y[l] >= 0) begin
               x_in = vec_y[l];
               y_in = -vec_x[l];
               z_in = Quarter;
            end else begin
               x_in = -vec_y[l];
               y_in = vec_x[l];
               z_in = -Quarter;
            end
         end
      end

      always_ff @(posedge clock) begin
         x_ff[0][l]    <= x_in;
         y_ff[0][l]    <= y_in;
         z_ff[0][l]    <= z_in;
         zero_ff[0][l] <= (vec_x[l] == 0) && (vec_y[l] == 0);
      end

      for (genvar i = 0; i < STEPS; i++) begin : g_step
         localparam logic [31:0] TabVal = tab_entry(i, 32 - ANGLE_BITS);
         localparam logic signed [ZW-1:0] Ang = ZW'(TabVal);
         logic signed [VecW-1:0] dx, dy, xs_in, ys_in;
         logic signed [ZW-1:0]   zs_in;

         always_comb begin
            dx = y_ff[i][l] >>> i;
            dy = x_ff[i][l] >>> i;
            if (!y_ff[i][l][VecW-1]) begin
               xs_in = x_ff[i][l] + dx;
               ys_in = y_ff[i][l] - dy;
               zs_in = z_ff[i][l] + Ang;
            end else begin
               xs_in = x_ff[i][l] - dx;
               ys_in = y_ff[i][l] + dy;
               zs_in = z_ff[i][l] - Ang;
            end
         end

         always_ff @(posedge clock) begin
            x_ff[i+1][l]    <= xs_in;
            y_ff[i+1][l]    <= ys_in;
            z_ff[i+1][l]    <= zs_in;
            zero_ff[i+1][l] <= zero_ff[i][l];
         end
      end

      // atan2(0, 0) is zero
      assign angle[l] = zero_ff[STEPS][l] ? '0 : z_ff[STEPS][l];
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_valid
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i+1] <= 1'b0;
         end else begin
            valid_ff[i+1] <= valid_ff[i];
         end
      end
   end

   assign out_valid = valid_ff[STEPS];

endmodule

[sv/quaternion_to_euler_angles_unit.sv]
// ----------------------------------------------------------------------------
// Quaternion to Euler angles unit
// Heading, pitch and bank from a Q1.15 quaternion, fully pipelined.
// ----------------------------------------------------------------------------
// A transaction enters when start is high and busy is low; busy stays low,
// so a new quaternion may enter on every cycle. req_kind picks the
// direction: 0 object-to-inertial, 1 inertial-to-object.
// Results come out in order, each on the rsp_ ports for one cycle with
// rsp_valid high. Angles are binary, 32768 = pi. When |sin pitch| exceeds
// the lock threshold, rsp_gimbal_locked is set and bank reads zero.
// The pipeline has 3 front-end stages, 31 square-root stages, a pre-rotation
// stage plus one stage per CORDIC step, and the output register.
// Throughput is one transaction per cycle.
// The csr_ channel writes the 15-bit lock threshold and is always ready. The
// user must write it only while the pipeline is empty; it is not enforced.
// Reset clears all valid bits and sets the threshold to 32765. The
// receiver cannot stall, so nothing is ever held back.
// ----------------------------------------------------------------------------
`include "quaternion_to_euler_angles_unit_macros.svh"

module quaternion_to_euler_angles_unit #(
   parameter int CORDIC_STEPS = 16,
   parameter int ANGLE_BITS   = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_kind,
   input  logic signed [15:0] req_quat_w,
   input  logic signed [15:0] req_quat_x,
   input  logic signed [15:0] req_quat_y,
   input  logic signed [15:0] req_quat_z,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [14:0]        csr_wdata,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_heading_angle,
   output logic signed [15:0] rsp_pitch_angle,
   output logic signed [15:0] rsp_bank_angle,
   output logic               rsp_gimbal_locked
);
   import qtea_pkg::*;

   localparam int ZW = ANGLE_BITS + 2;

   // lock threshold register
   logic [14:0] lock_threshold_ff;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         lock_threshold_ff <= 15'd32765;
      end else if (csr_valid && csr_ready) begin
         lock_threshold_ff <= csr_wdata;
      end
   end

   // front end
   logic           front_valid;
   side_type       front_side;
   logic [SqW-1:0] front_operand;

   qtea_front u_front (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (start && !busy),
      .kind           (req_kind),
      .quat_w         (req_quat_w),
      .quat_x         (req_quat_x),
      .quat_y         (req_quat_y),
      .quat_z         (req_quat_z),
      .lock_threshold (lock_threshold_ff),
      .out_valid      (front_valid),
      .side           (front_side),
      .operand        (front_operand)
   );

   // cos(pitch) by square root, sideband delayed alongside
   logic             sqrt_valid;
   logic [RootW-1:0] sqrt_root;
   side_type         side_d;

   qtea_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .operand   (front_operand),
      .out_valid (sqrt_valid),
      .root      (sqrt_root)
   );

   qtea_delay #(
      .WIDTH ($bits(side_type)),
      .DEPTH (SqrtStages)
   ) u_side_delay (
      .clock (clock),
      .din   (front_side),
      .dout  (side_d)
   );

   // three atan2 lanes
   logic signed [VecW-1:0] lane_y [NumLanes];
   logic signed [VecW-1:0] lane_x [NumLanes];
   logic signed [ZW-1:0]   lane_angle [NumLanes];
   logic                   cordic_valid;
   lock_type               lock_d;

   always_comb begin
      lane_y[LaneHeading] = side_d.hy;
      lane_x[LaneHeading] = side_d.hx;
      lane_y[LanePitch]   = side_d.s;
      lane_x[LanePitch]   = VecW'(sqrt_root);
      lane_y[LaneBank]    = side_d.by;
      lane_x[LaneBank]    = side_d.bx;
   end

   qtea_cordic #(
      .STEPS      (CORDIC_STEPS),
      .ANGLE_BITS (ANGLE_BITS)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sqrt_valid),
      .vec_y     (lane_y),
      .vec_x     (lane_x),
      .out_valid (cordic_valid),
      .angle     (lane_angle)
   );

   qtea_delay #(
      .WIDTH ($bits(lock_type)),
      .DEPTH (CORDIC_STEPS + 1)
   ) u_lock_delay (
      .clock (clock),
      .din   (side_d.lk),
      .dout  (lock_d)
   );

   // scale accumulated angles to 16-bit binary angles
   logic signed [15:0] out_angle [NumLanes];

   for (genvar l = 0; l < NumLanes; l++) begin : g_scale
      if (ANGLE_BITS > 16) begin : g_round
         logic signed [ZW-1:0] rounded;
         assign rounded = (lane_angle[l] + (ZW'(1) << (ANGLE_BITS - 17)))
                          >>> (ANGLE_BITS - 16);
         assign out_angle[l] = rounded[15:0];
      end else begin : g_shift
         logic signed [ZW+15:0] widened;
         assign widened = (ZW+16)'(lane_angle[l]) <<< (16 - ANGLE_BITS);
         assign out_angle[l] = widened[15:0];
      end
   end

   // output register
   logic               rsp_valid_ff;
   logic signed [15:0] heading_ff, pitch_ff, bank_ff;
   logic               locked_ff;

   always_ff @(posedge clock) begin
      heading_ff <= out_angle[LaneHeading];
      pitch_ff   <= lock_d.locked ? lock_d.lock_pitch : out_angle[LanePitch];
      bank_ff    <= lock_d.locked ? 16'sd0 : out_angle[LaneBank];
      locked_ff  <= lock_d.locked;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cordic_valid;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_heading_angle = heading_ff;
   assign rsp_pitch_angle   = pitch_ff;
   assign rsp_bank_angle    = bank_ff;
   assign rsp_gimbal_locked = locked_ff;

   `QTEA_ASSERT_IMPLY(a_locked_bank_zero, clock, reset, rsp_valid && rsp_gimbal_locked, rsp_bank_angle == 16'sd0, "bank not zero under gimbal lock")
   `QTEA_ASSERT_IMPLY(a_locked_pitch_range, clock, reset, rsp_valid && rsp_gimbal_locked, (rsp_pitch_angle <= 16'sd16384) && (rsp_pitch_angle >= -16'sd16384), "locked pitch out of range")
   `QTEA_ASSERT_NEXT(a_csr_write_lands, clock, reset, csr_valid && csr_ready, lock_threshold_ff == $past(csr_wdata), "threshold write lost")

endmodule
